// ===== src/page_replacement_engine_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the page replacement engine.
// Each macro samples on the rising edge of clk and is disabled during reset.
// ---------------------------------------------------------------------------
`ifndef PAGE_REPLACEMENT_ENGINE_TOP_MACROS_SVH
`define PAGE_REPLACEMENT_ENGINE_TOP_MACROS_SVH

// Plain property check.
`define PRE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication.
`define PRE_ASSERT_IMP(lbl, pre, post, msg) `PRE_ASSERT(lbl, pre |-> post, msg)

// Next-cycle implication.
`define PRE_ASSERT_NEXT(lbl, pre, post, msg) `PRE_ASSERT(lbl, pre |=> post, msg)

`endif

// ===== src/pre_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pre_pkg
// Shared constants for the page replacement engine.
// ---------------------------------------------------------------------------
package pre_pkg;

  localparam int MAX_FRAMES_DEF       = 1024;
  localparam int PAGE_NUMBER_BITS_DEF = 22;

  // Stream and register port widths.
  localparam int IN_TDATA_W  = 40;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 168;
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;
  localparam int REG_IDX_W   = 2;

  // Register indexes.
  localparam logic [REG_IDX_W-1:0] REG_FRAME_COUNT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PAGE_SHIFT  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_POLICY      = 2'd2;

  // Register fields and reset values.
  localparam int FC_W    = 11;
  localparam int SHIFT_W = 4;
  localparam int POL_W   = 2;
  localparam logic [FC_W-1:0]    FC_RESET    = 11'd1024;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd12;

  // Replacement policies; the unused code behaves as fifo.
  localparam logic [POL_W-1:0] POL_FIFO  = 2'd0;
  localparam logic [POL_W-1:0] POL_CLOCK = 2'd1;
  localparam logic [POL_W-1:0] POL_LRU   = 2'd2;

  localparam logic ACT_WRITE = 1'b1;

  // Page table entry: flag bits low, frame index above them.
  localparam int ENT_FLAG_W = 4;
  localparam int E_PRESENT  = 0;
  localparam int E_DIRTY    = 1;
  localparam int E_REF      = 2;
  localparam int E_WRITTEN  = 3;

  // Result field widths.
  localparam int OUT_FRAME_W = 10;
  localparam int OUT_PAGE_W  = 22;
  localparam int CNT32_W     = 32;

endpackage

// ===== src/page_replacement_engine_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// page_replacement_engine_top
// Page table and frame ring with fifo, clock and lru-swap replacement.
// ---------------------------------------------------------------------------
//
//  Channel | Ports                               | Beat contents
//  --------+-------------------------------------+------------------------------
//  in      | in_tvalid/in_tready/in_tdata/tuser  | address; tuser = access kind
//  out     | out_tvalid/out_tready/out_tdata     | hit, frame, eviction, totals
//  cfg     | psel/penable/pwrite/paddr/pwdata    | frame_count, page_shift, policy
//
// Flow: one access is worked on at a time. A hit or a fill of a free frame
// passes through accept with the page table read, decision and final write;
// the final write also loads its result into the output register. An
// eviction adds the frame ring read and the victim's page table read, and in
// clock mode each referenced frame passed over repeats both. An lru swap adds
// a frame ring step and a page table step, plus the remainder unit when the
// ring head lies at or above the frame count and the newest slot needs it.
// The page table and the frame memory each have one read and one write port.
// Reset: after rst_n the page table is swept clear, one entry per cycle, over
// all 2**PAGE_NUMBER_BITS entries; no beat is accepted meanwhile, registers are.
// Stalls: the result sits in an output register; the next beat is taken while
// it waits, and only the final write of that next access waits for the slot.
// ---------------------------------------------------------------------------
module page_replacement_engine_top #(
  parameter int MAX_FRAMES       = pre_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_NUMBER_BITS = pre_pkg::PAGE_NUMBER_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: address[31:0], zero padding[39:32]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [pre_pkg::IN_TDATA_W-1:0]    in_tdata,
  // in_tuser: action[0] (0 read, 1 write)
  input  logic [pre_pkg::IN_TUSER_W-1:0]    in_tuser,
  // out_tdata: hit[0], frame[10:1], evicted_valid[11], evicted_page[33:12],
  // disk_write[34], disk_read[35], access_total[67:36], fault_total[99:68],
  // write_total[131:100], read_total[163:132], zero padding[167:164]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [pre_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pre_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [pre_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [pre_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam int FRAME_W = $clog2(MAX_FRAMES);
  localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
  localparam int PNB     = PAGE_NUMBER_BITS;
  localparam int FLAG_W  = pre_pkg::ENT_FLAG_W;
  localparam int ENT_W   = FLAG_W + FRAME_W;
  localparam int C_W     = pre_pkg::CNT32_W;

  typedef enum logic [8:0] {
    ST_CLEAR   = 9'b000000001,
    ST_IDLE    = 9'b000000010,
    ST_ENTRY   = 9'b000000100,
    ST_MOD     = 9'b000001000,
    ST_FR_WAIT = 9'b000010000,
    ST_PT_WAIT = 9'b000100000,
    ST_LRU_FR  = 9'b001000000,
    ST_LRU_PT  = 9'b010000000,
    ST_FIN     = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [pre_pkg::FC_W-1:0]    fc_r;
  logic [pre_pkg::SHIFT_W-1:0] shift_r;
  logic [pre_pkg::POL_W-1:0]   pol_r;
  logic                        cfg_wr;
  logic [pre_pkg::REG_IDX_W-1:0] reg_idx;

  // Control state.
  logic [PNB-1:0]     clr_r, clr_nxt;
  logic [FRAME_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0]   used_r, used_nxt;
  logic [CNT_W:0]     guard_r, guard_nxt;
  logic [C_W-1:0]     acc_r, acc_nxt, flt_r, flt_nxt, wbk_r, wbk_nxt, rdc_r, rdc_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Per-access payload.
  logic [PNB-1:0]     page_r, page_nxt;
  logic               wr_r, wr_nxt;
  logic [ENT_W-1:0]   entry_r, entry_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic [FRAME_W-1:0] newest_r, newest_nxt;
  logic               hit_r, hit_nxt;
  logic               evv_r, evv_nxt;
  logic [PNB-1:0]     evp_r, evp_nxt;
  logic               dwr_r, dwr_nxt;
  logic [PNB-1:0]     vp_r, vp_nxt;
  logic [PNB-1:0]     other_r, other_nxt;
  logic [pre_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // Memory ports.
  logic               pt_we, pt_re;
  logic [PNB-1:0]     pt_waddr, pt_raddr;
  logic [ENT_W-1:0]   pt_wdata, pt_rdata;
  logic               fr_we, fr_re;
  logic [FRAME_W-1:0] fr_waddr, fr_raddr;
  logic [PNB-1:0]     fr_wdata, fr_rdata;

  // Remainder unit.
  logic               rem_start, rem_done;
  logic [CNT_W-1:0]   rem_val;

  // Helpers.
  logic [CNT_W-1:0]   n_eff;
  logic [C_W-1:0]     addr_sh;
  logic [PNB-1:0]     in_page;
  logic [CNT_W:0]     head_inc;
  logic [FRAME_W-1:0] head_next;
  logic [FRAME_W-1:0] rd_frame;
  logic [FRAME_W-1:0] cur_frame;
  logic [FRAME_W-1:0] newest_sel;
  logic               do_check;
  logic [FLAG_W-1:0]  fin_flags;
  logic               dread;
  logic [C_W-1:0]     acc_inc, flt_inc, wbk_inc, rdc_inc;

  // -------------------------------------------------------------------------
  // Configuration port.
  // -------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[pre_pkg::CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r    <= pre_pkg::FC_RESET;
      shift_r <= pre_pkg::SHIFT_RESET;
      pol_r   <= pre_pkg::POL_FIFO;
    end else if (cfg_wr) begin
      case (reg_idx)
        pre_pkg::REG_FRAME_COUNT: fc_r    <= pwdata[pre_pkg::FC_W-1:0];
        pre_pkg::REG_PAGE_SHIFT:  shift_r <= pwdata[pre_pkg::SHIFT_W-1:0];
        pre_pkg::REG_POLICY:      pol_r   <= pwdata[pre_pkg::POL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pre_pkg::REG_FRAME_COUNT: prdata = pre_pkg::CFG_DATA_W'(fc_r);
      pre_pkg::REG_PAGE_SHIFT:  prdata = pre_pkg::CFG_DATA_W'(shift_r);
      pre_pkg::REG_POLICY:      prdata = pre_pkg::CFG_DATA_W'(pol_r);
      default:                  prdata = '0;
    endcase
  end

  // Effective frame count: zero acts as one, anything above the pool as the pool.
  always_comb begin
    if (fc_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (C_W'(fc_r) > C_W'(MAX_FRAMES)) begin
      n_eff = CNT_W'(MAX_FRAMES);
    end else begin
      n_eff = CNT_W'(fc_r);
    end
  end

  assign addr_sh   = in_tdata[C_W-1:0] >> shift_r;
  assign in_page   = PNB'(addr_sh);
  assign head_inc  = (CNT_W + 1)'(head_r) + 1'b1;
  assign head_next = (head_inc >= (CNT_W + 1)'(n_eff)) ? '0 : FRAME_W'(head_inc);
  assign rd_frame  = pt_rdata[ENT_W-1:FLAG_W];
  assign cur_frame = (state_r == ST_ENTRY) ? rd_frame : frame_r;

  assign acc_inc = (&acc_r) ? acc_r : acc_r + 1'b1;
  assign flt_inc = (&flt_r) ? flt_r : flt_r + 1'b1;
  assign wbk_inc = (&wbk_r) ? wbk_r : wbk_r + 1'b1;
  assign rdc_inc = (&rdc_r) ? rdc_r : rdc_r + 1'b1;

  assign dread = !hit_r && entry_r[pre_pkg::E_WRITTEN];

  // Final flags of the accessed page.
  always_comb begin
    if (hit_r) begin
      fin_flags = entry_r[FLAG_W-1:0];
      fin_flags[pre_pkg::E_REF] = 1'b1;
    end else begin
      fin_flags = '0;
      fin_flags[pre_pkg::E_WRITTEN] = entry_r[pre_pkg::E_WRITTEN];
      fin_flags[pre_pkg::E_PRESENT] = 1'b1;
    end
    if (wr_r) begin
      fin_flags[pre_pkg::E_WRITTEN] = 1'b1;
      fin_flags[pre_pkg::E_DIRTY]   = 1'b1;
    end
  end

  // -------------------------------------------------------------------------
  // Sequencer.
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    head_nxt      = head_r;
    used_nxt      = used_r;
    guard_nxt     = guard_r;
    acc_nxt       = acc_r;
    flt_nxt       = flt_r;
    wbk_nxt       = wbk_r;
    rdc_nxt       = rdc_r;
    page_nxt      = page_r;
    wr_nxt        = wr_r;
    entry_nxt     = entry_r;
    frame_nxt     = frame_r;
    newest_nxt    = newest_r;
    hit_nxt       = hit_r;
    evv_nxt       = evv_r;
    evp_nxt       = evp_r;
    dwr_nxt       = dwr_r;
    vp_nxt        = vp_r;
    other_nxt     = other_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    pt_we         = 1'b0;
    pt_waddr      = page_r;
    pt_wdata      = entry_r;
    pt_re         = 1'b0;
    pt_raddr      = page_r;
    fr_we         = 1'b0;
    fr_waddr      = frame_r;
    fr_wdata      = page_r;
    fr_re         = 1'b0;
    fr_raddr      = head_r;
    rem_start     = 1'b0;
    newest_sel    = newest_r;
    do_check      = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        pt_we    = 1'b1;
        pt_waddr = clr_r;
        pt_wdata = '0;
        clr_nxt  = clr_r + 1'b1;
        if (&clr_r) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_tvalid) begin
          page_nxt  = in_page;
          wr_nxt    = (in_tuser[0] == pre_pkg::ACT_WRITE);
          pt_re     = 1'b1;
          pt_raddr  = in_page;
          state_nxt = ST_ENTRY;
        end
      end

      ST_ENTRY: begin
        entry_nxt = pt_rdata;
        hit_nxt   = pt_rdata[pre_pkg::E_PRESENT];
        evv_nxt   = 1'b0;
        evp_nxt   = '0;
        dwr_nxt   = 1'b0;
        if (pt_rdata[pre_pkg::E_PRESENT]) begin
          frame_nxt = rd_frame;
          if (pol_r == pre_pkg::POL_LRU) begin
            if (used_r < n_eff) begin
              newest_sel = FRAME_W'(used_r - 1'b1);
              do_check   = 1'b1;
            end else if (CNT_W'(head_r) < n_eff) begin
              newest_sel = (head_r == '0) ? FRAME_W'(n_eff - 1'b1) : head_r - 1'b1;
              do_check   = 1'b1;
            end else begin
              // Head left above a shrunken frame count: take the remainder.
              rem_start = 1'b1;
              state_nxt = ST_MOD;
            end
          end else begin
            state_nxt = ST_FIN;
          end
        end else if (used_r < n_eff) begin
          frame_nxt = FRAME_W'(used_r);
          used_nxt  = used_r + 1'b1;
          state_nxt = ST_FIN;
        end else begin
          fr_re     = 1'b1;
          fr_raddr  = head_r;
          guard_nxt = '0;
          state_nxt = ST_FR_WAIT;
        end
      end

      ST_MOD: begin
        if (rem_done) begin
          newest_sel = FRAME_W'(rem_val);
          do_check   = 1'b1;
        end
      end

      ST_FR_WAIT: begin
        vp_nxt    = fr_rdata;
        pt_re     = 1'b1;
        pt_raddr  = fr_rdata;
        state_nxt = ST_PT_WAIT;
      end

      ST_PT_WAIT: begin
        pt_we    = 1'b1;
        pt_waddr = vp_r;
        pt_wdata = pt_rdata;
        if (pol_r == pre_pkg::POL_CLOCK && pt_rdata[pre_pkg::E_REF] &&
            guard_r <= (CNT_W + 1)'(n_eff)) begin
          // Second chance: clear the bit and move on.
          pt_wdata[pre_pkg::E_REF] = 1'b0;
          head_nxt  = head_next;
          guard_nxt = guard_r + 1'b1;
          fr_re     = 1'b1;
          fr_raddr  = head_next;
          state_nxt = ST_FR_WAIT;
        end else begin
          pt_wdata[pre_pkg::E_PRESENT] = 1'b0;
          frame_nxt = head_r;
          head_nxt  = head_next;
          evv_nxt   = 1'b1;
          evp_nxt   = vp_r;
          dwr_nxt   = pt_rdata[pre_pkg::E_DIRTY];
          state_nxt = ST_FIN;
        end
      end

      ST_LRU_FR: begin
        other_nxt = fr_rdata;
        fr_we     = 1'b1;
        fr_waddr  = newest_r;
        fr_wdata  = page_r;
        pt_re     = 1'b1;
        pt_raddr  = fr_rdata;
        state_nxt = ST_LRU_PT;
      end

      ST_LRU_PT: begin
        pt_we     = 1'b1;
        pt_waddr  = other_r;
        pt_wdata  = {frame_r, pt_rdata[FLAG_W-1:0]};
        fr_we     = 1'b1;
        fr_waddr  = frame_r;
        fr_wdata  = other_r;
        frame_nxt = newest_r;
        state_nxt = ST_FIN;
      end

      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          pt_we    = 1'b1;
          pt_waddr = page_r;
          pt_wdata = {frame_r, fin_flags};
          if (!hit_r) begin
            fr_we    = 1'b1;
            fr_waddr = frame_r;
            fr_wdata = page_r;
            flt_nxt  = flt_inc;
          end
          acc_nxt = acc_inc;
          if (dwr_r) begin
            wbk_nxt = wbk_inc;
          end
          if (dread) begin
            rdc_nxt = rdc_inc;
          end
          out_data_nxt = {4'b0,
                          dread ? rdc_inc : rdc_r,
                          dwr_r ? wbk_inc : wbk_r,
                          hit_r ? flt_r : flt_inc,
                          acc_inc,
                          dread, dwr_r,
                          pre_pkg::OUT_PAGE_W'(evp_r),
                          evv_r,
                          pre_pkg::OUT_FRAME_W'(frame_r),
                          hit_r};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // LRU: swap with the newest slot unless the page already sits there.
    if (do_check) begin
      newest_nxt = newest_sel;
      if (newest_sel != cur_frame) begin
        fr_re     = 1'b1;
        fr_raddr  = newest_sel;
        state_nxt = ST_LRU_FR;
      end else begin
        state_nxt = ST_FIN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      head_r      <= '0;
      used_r      <= '0;
      guard_r     <= '0;
      acc_r       <= '0;
      flt_r       <= '0;
      wbk_r       <= '0;
      rdc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      head_r      <= head_nxt;
      used_r      <= used_nxt;
      guard_r     <= guard_nxt;
      acc_r       <= acc_nxt;
      flt_r       <= flt_nxt;
      wbk_r       <= wbk_nxt;
      rdc_r       <= rdc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r     <= page_nxt;
    wr_r       <= wr_nxt;
    entry_r    <= entry_nxt;
    frame_r    <= frame_nxt;
    newest_r   <= newest_nxt;
    hit_r      <= hit_nxt;
    evv_r      <= evv_nxt;
    evp_r      <= evp_nxt;
    dwr_r      <= dwr_nxt;
    vp_r       <= vp_nxt;
    other_r    <= other_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // -------------------------------------------------------------------------
  // Memories and the remainder unit.
  // -------------------------------------------------------------------------
  pre_page_ram #(
    .AW (PNB),
    .DW (ENT_W)
  ) u_page_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .re    (pt_re),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  pre_frame_ram #(
    .DEPTH (MAX_FRAMES),
    .DW    (PNB)
  ) u_frame_ram (
    .clk   (clk),
    .we    (fr_we),
    .waddr (fr_waddr),
    .wdata (fr_wdata),
    .re    (fr_re),
    .raddr (fr_raddr),
    .rdata (fr_rdata)
  );

  pre_urem #(
    .A_W (FRAME_W),
    .B_W (CNT_W)
  ) u_urem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (rem_start),
    .dividend  (head_r - 1'b1),
    .divisor   (n_eff),
    .done      (rem_done),
    .remainder (rem_val)
  );

endmodule

// ===== src/pre_page_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pre_page_ram
// Page table memory: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module pre_page_ram #(
  parameter int AW = 22,
  parameter int DW = 14
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/pre_frame_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pre_frame_ram
// Frame-to-page memory: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module pre_frame_ram #(
  parameter int DEPTH = 1024,
  parameter int DW    = 22
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/pre_urem.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pre_urem
// Restoring remainder unit, one dividend bit per cycle.
// ---------------------------------------------------------------------------
module pre_urem #(
  parameter int A_W = 10,
  parameter int B_W = 11
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [A_W-1:0] dividend,
  input  logic [B_W-1:0] divisor,
  output logic           done,
  output logic [B_W-1:0] remainder
);

  localparam int CW = $clog2(A_W + 1);

  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [A_W-1:0] quo_r, quo_nxt;
  logic [B_W-1:0] rem_r, rem_nxt;
  logic [B_W-1:0] div_r, div_nxt;
  logic [B_W:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    trial    = {rem_r, quo_r[A_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(A_W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        trial = trial - {1'b0, div_r};
      end
      rem_nxt = trial[B_W-1:0];
      quo_nxt = quo_r << 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

// ===== src/pre_port_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pre_port_checker
// Port-level checks on the result stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "page_replacement_engine_top_macros.svh"

module pre_port_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [pre_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic hit, ev_valid, dwrite, dread;
  logic [pre_pkg::CNT32_W-1:0] acc_total;

  assign hit       = out_tdata[0];
  assign ev_valid  = out_tdata[11];
  assign dwrite    = out_tdata[34];
  assign dread     = out_tdata[35];
  assign acc_total = out_tdata[67:36];

  `PRE_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result beat changed while stalled")
  `PRE_ASSERT_IMP(a_hit_clean, out_tvalid && hit, !ev_valid && !dwrite && !dread, "hit reports eviction or disk traffic")
  `PRE_ASSERT_IMP(a_wb_evict, out_tvalid && dwrite, ev_valid, "write-back without eviction")
  `PRE_ASSERT_IMP(a_acc_nonzero, out_tvalid, acc_total != '0, "access total zero on a result")

endmodule

bind page_replacement_engine_top pre_port_checker u_port_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the page replacement engine.
// ---------------------------------------------------------------------------
// A queue of accesses feeds a clocked driver on the in stream. Each accepted
// beat runs through a page-table model kept here. That model has its own
// frame ring and counters. The predicted result is queued, and a clocked
// monitor compares every out beat with it field by field. The run steps
// through several register settings. The extremes are among them: a single
// frame, frame counts of 0 and 2047, page shifts of 0 and 15, and the unused
// policy code. Each new setting is written over APB only once the engine has
// drained.
// ---------------------------------------------------------------------------
module testbench;

  typedef struct {
    bit        act;
    bit [31:0] addr;
  } access_t;

  typedef struct {
    bit        hit;
    bit [9:0]  frame;
    bit        ev_valid;
    bit [21:0] ev_page;
    bit        disk_wr;
    bit        disk_rd;
    bit [31:0] acc_tot;
    bit [31:0] flt_tot;
    bit [31:0] wr_tot;
    bit [31:0] rd_tot;
  } outcome_t;

  localparam int        NFR       = pre_pkg::MAX_FRAMES_DEF;
  localparam bit [21:0] PAGE_MASK = 22'h3FFFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [pre_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic [pre_pkg::IN_TUSER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [pre_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [pre_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [pre_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [pre_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  page_replacement_engine_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // Shadow copy of the register settings, updated as each APB write lands.
  bit [pre_pkg::FC_W-1:0]    sh_frames = pre_pkg::FC_RESET;
  bit [pre_pkg::SHIFT_W-1:0] sh_shift  = pre_pkg::SHIFT_RESET;
  bit [pre_pkg::POL_W-1:0]   sh_policy = pre_pkg::POL_FIFO;

  // Page table model: bit 0 present, 1 dirty, 2 referenced, 3 written, and
  // the frame index above the flags. A missing key reads as an all-zero entry.
  bit [15:0] page_tbl [bit [21:0]];
  bit [21:0] frame_owner [NFR];
  int unsigned ring_head = 0;
  int unsigned frames_used = 0;
  bit [31:0] acc_cnt = 0, flt_cnt = 0, wb_cnt = 0, rd_cnt = 0;

  access_t  pending_accesses[$];
  outcome_t predicted_results[$];
  access_t  beat_on_bus;
  bit       quiet = 1'b0;
  int       errors = 0;
  int       n_hits = 0, n_evicts = 0, n_disk_wr = 0, n_disk_rd = 0, n_checked = 0;

  function automatic bit [31:0] sat_inc(bit [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic bit [15:0] pte(bit [21:0] p);
    return page_tbl.exists(p) ? page_tbl[p] : 16'h0;
  endfunction

  function automatic bit pte_ref(bit [21:0] p);
    bit [15:0] e;
    e = pte(p);
    return e[pre_pkg::E_REF];
  endfunction

  function automatic void set_pte_frame(bit [21:0] p, int unsigned f);
    bit [15:0] e;
    e = pte(p);
    e[15:pre_pkg::ENT_FLAG_W] = f[11:0];
    page_tbl[p] = e;
  endfunction

  function automatic int unsigned step_ring(int unsigned h, int unsigned n);
    return (h + 1 >= n) ? 0 : h + 1;
  endfunction

  // Work out the result of one accepted access and advance the page table model.
  task automatic predict_access(access_t a);
    outcome_t    r;
    bit [21:0]   pg, other, vp;
    bit [15:0]   e;
    int unsigned n, newest, guard, victim, f;
    r = '{default: 0};
    pg = 22'(a.addr >> sh_shift);
    n = (sh_frames == 0) ? 1 : (sh_frames > NFR) ? NFR : sh_frames;
    acc_cnt = sat_inc(acc_cnt);
    e = pte(pg);
    if (e[pre_pkg::E_PRESENT]) begin
      r.hit = 1'b1;
      e[pre_pkg::E_REF] = 1'b1;
      page_tbl[pg] = e;
      f = e[15:pre_pkg::ENT_FLAG_W];
      // In lru mode the page trades frames with the newest ring slot.
      if (sh_policy == pre_pkg::POL_LRU) begin
        newest = (frames_used < n) ? frames_used - 1 : (ring_head + n - 1) % n;
        if (newest != f && newest < NFR && f < NFR) begin
          other = frame_owner[newest];
          frame_owner[newest] = pg;
          frame_owner[f] = other;
          set_pte_frame(other, f);
          set_pte_frame(pg, newest);
          f = newest;
        end
      end
      n_hits++;
    end else begin
      flt_cnt = sat_inc(flt_cnt);
      if (frames_used < n) begin
        f = frames_used;
        frames_used++;
      end else begin
        if (sh_policy == pre_pkg::POL_CLOCK) begin
          // Clock sweep: referenced frames get a second chance.
          guard = 0;
          while (guard <= n && pte_ref(frame_owner[ring_head % NFR])) begin
            vp = frame_owner[ring_head % NFR];
            e = pte(vp);
            e[pre_pkg::E_REF] = 1'b0;
            page_tbl[vp] = e;
            ring_head = step_ring(ring_head, n);
            guard++;
          end
        end
        victim = ring_head % NFR;
        ring_head = step_ring(ring_head, n);
        r.ev_page = frame_owner[victim];
        r.ev_valid = 1'b1;
        e = pte(r.ev_page);
        if (e[pre_pkg::E_DIRTY]) begin
          r.disk_wr = 1'b1;
          wb_cnt = sat_inc(wb_cnt);
          n_disk_wr++;
        end
        e[pre_pkg::E_PRESENT] = 1'b0;
        page_tbl[r.ev_page] = e;
        f = victim;
        n_evicts++;
      end
      frame_owner[f % NFR] = pg;
      e = pte(pg);
      if (e[pre_pkg::E_WRITTEN]) begin
        r.disk_rd = 1'b1;
        rd_cnt = sat_inc(rd_cnt);
        n_disk_rd++;
      end
      e = e & (16'h1 << pre_pkg::E_WRITTEN);
      e[pre_pkg::E_PRESENT] = 1'b1;
      page_tbl[pg] = e;
      set_pte_frame(pg, f);
    end
    if (a.act == pre_pkg::ACT_WRITE) begin
      e = pte(pg);
      e[pre_pkg::E_WRITTEN] = 1'b1;
      e[pre_pkg::E_DIRTY] = 1'b1;
      page_tbl[pg] = e;
    end
    r.frame = f[9:0];
    r.acc_tot = acc_cnt;
    r.flt_tot = flt_cnt;
    r.wr_tot = wb_cnt;
    r.rd_tot = rd_cnt;
    predicted_results.push_back(r);
  endtask

  // Driver: a beat stays on the bus until it is accepted, then the next one
  // may follow straight away or after a random idle gap.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_access(beat_on_bus);
      if (!in_tvalid || in_tready) begin
        if (pending_accesses.size() > 0 && (quiet || $urandom_range(0, 99) >= 8)) begin
          beat_on_bus = pending_accesses.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {8'h00, beat_on_bus.addr};
          in_tuser  <= beat_on_bus.act;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, longint unsigned exp_v,
                                      longint unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: mismatch in %s, expected 0x%0h, actual 0x%0h", $realtime, name,
               exp_v, act_v);
      errors++;
    end
  endfunction

  // Monitor: random backpressure on the result stream, none while quiet. Every
  // accepted result is checked against the oldest prediction.
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual 0x%0h", $realtime,
                   out_tdata);
          errors++;
        end else begin
          want = predicted_results.pop_front();
          check_field("hit", want.hit, out_tdata[0]);
          check_field("frame", want.frame, out_tdata[10:1]);
          check_field("evicted_valid", want.ev_valid, out_tdata[11]);
          check_field("evicted_page", want.ev_page, out_tdata[33:12]);
          check_field("disk_write", want.disk_wr, out_tdata[34]);
          check_field("disk_read", want.disk_rd, out_tdata[35]);
          check_field("access_total", want.acc_tot, out_tdata[67:36]);
          check_field("fault_total", want.flt_tot, out_tdata[99:68]);
          check_field("write_total", want.wr_tot, out_tdata[131:100]);
          check_field("read_total", want.rd_tot, out_tdata[163:132]);
          n_checked++;
        end
      end
      out_tready <= quiet || ($urandom_range(0, 99) >= 8);
    end
  end

  // APB write: a setup phase, then an access phase; the register takes the
  // value at the edge that ends the access phase.
  task automatic cfg_write(bit [pre_pkg::REG_IDX_W-1:0] idx, bit [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= pre_pkg::CFG_ADDR_W'(idx) << 2;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      pre_pkg::REG_FRAME_COUNT: sh_frames = val[pre_pkg::FC_W-1:0];
      pre_pkg::REG_PAGE_SHIFT:  sh_shift  = val[pre_pkg::SHIFT_W-1:0];
      default:                  sh_policy = val[pre_pkg::POL_W-1:0];
    endcase
  endtask

  // Wait until the engine has drained: nothing queued, on the bus or owed.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_accesses.size() != 0 || in_tvalid || predicted_results.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic queue_access(bit act, bit [21:0] pg);
    access_t a;
    bit [31:0] offs;
    offs = (sh_shift == 0) ? 32'h0 : ($urandom() & ((32'h1 << sh_shift) - 1));
    a.act = act;
    a.addr = (32'(pg) << sh_shift) | offs;
    pending_accesses.push_back(a);
  endtask

  initial begin
    int unsigned cfgs [9][3] = '{
      '{1024, 12, pre_pkg::POL_FIFO}, '{4, 12, pre_pkg::POL_CLOCK},
      '{8, 10, pre_pkg::POL_LRU}, '{1, 14, pre_pkg::POL_FIFO}, '{16, 13, 3},
      '{5, 15, pre_pkg::POL_CLOCK}, '{0, 0, pre_pkg::POL_LRU},
      '{2047, 11, pre_pkg::POL_LRU}, '{3, 11, pre_pkg::POL_CLOCK}};
    bit [21:0] work_set[$];
    access_t   a;
    int        ws_size;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: address extremes under the reset settings.
    a.act = 1'b0; a.addr = 32'h0000_0000; pending_accesses.push_back(a);
    a.act = 1'b1; a.addr = 32'hFFFF_FFFF; pending_accesses.push_back(a);
    a.act = 1'b0; a.addr = 32'hFFFF_F000; pending_accesses.push_back(a);
    a.act = 1'b1; a.addr = 32'h0000_0FFF; pending_accesses.push_back(a);
    wait_drained();

    // Directed: two frames in clock mode with 1 KiB pages, so evictions,
    // write-backs of dirty victims and reloads of written pages all occur.
    cfg_write(pre_pkg::REG_FRAME_COUNT, 2);
    cfg_write(pre_pkg::REG_PAGE_SHIFT, 10);
    cfg_write(pre_pkg::REG_POLICY, pre_pkg::POL_CLOCK);
    queue_access(1'b1, 22'd1);
    queue_access(1'b0, 22'd2);
    queue_access(1'b0, 22'd1);
    queue_access(1'b0, 22'd3);
    queue_access(1'b1, 22'd4);
    queue_access(1'b0, 22'd1);
    queue_access(1'b0, 22'd3);
    queue_access(1'b1, 22'h3FFFFF);
    queue_access(1'b0, 22'd4);
    queue_access(1'b0, 22'd1);
    queue_access(1'b1, 22'd1);
    queue_access(1'b0, 22'd2);
    wait_drained();

    // Random phases. State carries across phases, so the frame count also
    // changes under a partly or fully used ring.
    foreach (cfgs[i]) begin
      cfg_write(pre_pkg::REG_FRAME_COUNT, cfgs[i][0]);
      cfg_write(pre_pkg::REG_PAGE_SHIFT, cfgs[i][1]);
      cfg_write(pre_pkg::REG_POLICY, cfgs[i][2]);
      quiet = (i == 4);
      work_set.delete();
      ws_size = ((sh_frames == 0) ? 1 : (sh_frames > 48) ? 48 : sh_frames)
                + $urandom_range(1, 4);
      repeat (ws_size) work_set.push_back(22'($urandom_range(0, 2**22 - 1)));
      repeat (190) begin
        if ($urandom_range(0, 99) < 85) begin
          queue_access($urandom_range(0, 99) < 30, work_set[$urandom_range(0, ws_size - 1)]);
        end else begin
          a.act = 1'($urandom_range(0, 1));
          a.addr = $urandom();
          pending_accesses.push_back(a);
        end
      end
      wait_drained();
    end
    quiet = 1'b0;
    repeat (50) @(posedge clk);

    $display("Checked %0d results: %0d hits, %0d evictions, %0d write-backs, %0d reloads.",
             n_checked, n_hits, n_evicts, n_disk_wr, n_disk_rd);
    $display("Covered fifo, clock, lru and the unused policy code, frame counts 0 to 2047.");
    if (errors == 0 && predicted_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // The page table sweep after reset alone clears all 2**22 entries.
  initial begin
    #400_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
